FILE: src/esp_pkg.sv
// Shared types and constants for the encoder speed and position unit.
package esp_pkg;

  localparam int unsigned RES_W  = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned DEN_W  = 48;
  localparam int unsigned PMAG_W = 32;

  // Request codes
  localparam logic [1:0] REQ_EDGE  = 2'd0;
  localparam logic [1:0] REQ_SPEED = 2'd1;
  localparam logic [1:0] REQ_POS   = 2'd2;

  // Unit codes
  localparam logic [1:0] MODE_DEG = 2'd0;
  localparam logic [1:0] MODE_RAD = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_CPR       = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [1:0] CFG_MAX_STEP  = 2'd2;

  localparam logic [15:0] CPR_RESET       = 16'd1024;
  localparam logic [15:0] MAX_SPEED_RESET = 16'd800;
  localparam logic [15:0] MAX_STEP_RESET  = 16'd100;
  localparam logic [19:0] PERIOD_RESET    = 20'd1000000;

  // Scale constants; 2*pi values carry 16 fraction bits
  localparam logic [28:0] DEG_SPEED_K     = 29'd360000000;
  localparam logic [38:0] RAD_SPEED_K_Q16 = 39'd411774832291;
  localparam logic [18:0] TWO_PI_Q16      = 19'd411775;
  localparam logic [8:0]  DEG_PER_REV     = 9'd360;

  localparam logic [RES_W-1:0] RES_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] RES_NEG_MAG = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_SPEED,
    OP_POS,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [CFG_W-1:0] cpr;
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] max_step;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [1:0]        mode;
    logic              per_neg;
    logic [PMAG_W-1:0] per_mag;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

FILE: src/esp_front.sv
// Front end: accepts transactions, tracks edge state and builds commands.
module esp_front #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   timestamp_us_i,
  input  logic          chb_level_i,
  input  logic [1:0]    unit_mode_i,
  input  logic          full_i,
  output logic          push_o,
  output esp_pkg::cmd_t cmd_o
);
  import esp_pkg::*;

  localparam int PER_W = (TIME_BITS > 20) ? TIME_BITS : 20;

  logic [TIME_BITS-1:0] last_q, last_d;
  logic [PER_W-1:0]     per_mag_q, per_mag_d;
  logic                 per_neg_q, per_neg_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TIME_BITS-1:0] period;
  logic                 accept;
  op_e                  op;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;
  assign period     = timestamp_us_i[TIME_BITS-1:0] - last_q;

  always_comb begin
    unique case (req_type_i)
      REQ_EDGE:  op = OP_EDGE;
      REQ_SPEED: op = OP_SPEED;
      REQ_POS:   op = OP_POS;
      default:   op = OP_NONE;
    endcase
  end

  always_comb begin
    last_d    = last_q;
    per_mag_d = per_mag_q;
    per_neg_d = per_neg_q;
    count_d   = count_q;
    if (accept && op == OP_EDGE) begin
      last_d    = timestamp_us_i[TIME_BITS-1:0];
      per_mag_d = PER_W'(period);
      // a zero period stays positive
      per_neg_d = ~chb_level_i & (period != '0);
      count_d   = chb_level_i ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      per_mag_q <= PER_W'(PERIOD_RESET);
      per_neg_q <= 1'b0;
      count_q   <= '0;
    end else begin
      last_q    <= last_d;
      per_mag_q <= per_mag_d;
      per_neg_q <= per_neg_d;
      count_q   <= count_d;
    end
  end

  always_comb begin
    cmd_o.op      = op;
    cmd_o.mode    = unit_mode_i;
    cmd_o.per_neg = per_neg_d;
    cmd_o.per_mag = PMAG_W'(per_mag_d);
    cmd_o.count   = count_d;
  end

endmodule

FILE: src/esp_fifo.sv
// Short command queue between the front end and the execution back end.
module esp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/esp_div.sv
// Restoring divider, one quotient bit per cycle.
module esp_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = ~diff[DEN_W];
  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

FILE: src/esp_back.sv
// Back end: scales, divides and saturates, limits degree speed, then holds the result.
module esp_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  esp_pkg::cmd_t               cmd_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  esp_pkg::cfg_t               cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [esp_pkg::RES_W-1:0]   result_value_o,
  output logic [esp_pkg::CNT_W-1:0]   count_now_o
);
  import esp_pkg::*;

  localparam int NUM_W      = (40 + FRAC_BITS > 50) ? 40 + FRAC_BITS : 50;
  localparam int POS_RAD_SH = 16 - FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN,
    S_LIM1,
    S_LIM2,
    S_OUT
  } state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [RES_W-1:0] vel_q, prev_q;
  logic             out_valid_q;
  logic [RES_W-1:0] out_res_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic             is_speed, is_rad, cnt_neg, neg, den_zero, live;
  logic [CNT_W-1:0] cmag;
  logic [DEN_W-1:0] spd_den, div_den;
  logic [39:0]      pos_deg_prod;
  logic [49:0]      pos_rad_prod;
  logic [NUM_W-1:0] div_num, div_quo, q_sh;
  logic             div_start, div_busy;
  logic [RES_W-1:0] lim48, mag48, vel_fin;
  logic             sat;
  logic [RES_W-1:0] vel_abs, spd_lim;
  logic [RES_W:0]   vdiff, vdiff_abs, step_lim;
  logic             out_free;

  assign is_speed = (cmd_q.op == OP_SPEED);
  assign is_rad   = (cmd_q.mode == MODE_RAD);
  assign cnt_neg  = cmd_q.count[CNT_W-1];
  assign cmag     = cnt_neg ? -cmd_q.count : cmd_q.count;
  assign neg      = is_speed ? cmd_q.per_neg : cnt_neg;
  assign den_zero = (cfg_i.cpr == '0) || (is_speed && cmd_q.per_mag == '0);

  // commands that reach the divider
  assign live = ((cmd_i.op == OP_SPEED) || (cmd_i.op == OP_POS)) &&
                ((cmd_i.mode == MODE_DEG) || (cmd_i.mode == MODE_RAD));

  assign spd_den      = cfg_i.cpr * cmd_q.per_mag;
  assign pos_deg_prod = cmag * DEG_PER_REV;
  assign pos_rad_prod = cmag * TWO_PI_Q16;

  always_comb begin
    if (is_speed) begin
      div_den = spd_den;
      div_num = is_rad ? NUM_W'(RAD_SPEED_K_Q16) << FRAC_BITS
                       : NUM_W'(DEG_SPEED_K) << FRAC_BITS;
    end else begin
      div_den = DEN_W'(cfg_i.cpr);
      div_num = is_rad ? NUM_W'(pos_rad_prod)
                       : NUM_W'(pos_deg_prod) << FRAC_BITS;
    end
  end

  assign div_start = (state_q == S_MUL);

  esp_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // drop the 2*pi fraction bits, then saturate and apply the sign
  always_comb begin
    if (is_rad && is_speed) begin
      q_sh = div_quo >> 16;
    end else if (is_rad) begin
      q_sh = div_quo >> POS_RAD_SH;
    end else begin
      q_sh = div_quo;
    end
    lim48   = neg ? RES_NEG_MAG : RES_POS_MAX;
    sat     = den_zero || (q_sh > NUM_W'(lim48));
    mag48   = sat ? lim48 : q_sh[RES_W-1:0];
    vel_fin = neg ? -mag48 : mag48;
  end

  assign vel_abs   = vel_q[RES_W-1] ? -vel_q : vel_q;
  assign spd_lim   = RES_W'(cfg_i.max_speed) << FRAC_BITS;
  assign vdiff     = {vel_q[RES_W-1], vel_q} - {prev_q[RES_W-1], prev_q};
  assign vdiff_abs = vdiff[RES_W] ? -vdiff : vdiff;
  assign step_lim  = (RES_W+1)'(cfg_i.max_step) << FRAC_BITS;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = (state_q == S_IDLE) & ~empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      vel_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q <= cmd_i;
            if (live) begin
              state_q <= S_MUL;
            end else begin
              vel_q <= '0;
              if (cmd_i.op == OP_SPEED) begin
                prev_q <= '0;
              end
              state_q <= S_OUT;
            end
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          vel_q <= vel_fin;
          if (is_speed && !is_rad) begin
            state_q <= S_LIM1;
          end else begin
            if (is_speed) begin
              prev_q <= vel_fin;
            end
            state_q <= S_OUT;
          end
        end
        S_LIM1: begin
          // hold the previous speed when the magnitude is out of range
          if (vel_abs > spd_lim) begin
            vel_q <= prev_q;
          end
          state_q <= S_LIM2;
        end
        S_LIM2: begin
          if (vdiff_abs > step_lim) begin
            vel_q <= prev_q;
          end else begin
            prev_q <= vel_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_res_q <= vel_q;
            out_cnt_q <= cmd_q.count;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign count_now_o    = out_cnt_q;

endmodule

FILE: src/encoder_speed_position.sv
// Encoder speed and position unit: configuration, front end, queue and back end.
// Edge events, unused requests and unknown modes skip the divider and go straight to the output state.
// Speed and position queries run the one-bit-per-cycle divider with NUM_W = max(40 + FRAC_BITS, 50);
// degree speed then also passes through the limit states S_LIM1 and S_LIM2.
// Throughput: one transaction per back-end pass; a two-entry queue lets the front keep accepting until it fills.
// Reset: asynchronous, active low; counts_per_rev 1024, limits 800 and 100, period 1000000.
module encoder_speed_position #(
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [esp_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [31:0]                      timestamp_us_i,
  input  logic                             chb_level_i,
  input  logic [1:0]                       unit_mode_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [esp_pkg::RES_W-1:0] result_value_o,
  output logic signed [esp_pkg::CNT_W-1:0] count_now_o
);
  import esp_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  cfg_t             cfg_q;
  cmd_t             front_cmd;
  logic [CMD_W-1:0] fifo_rdata;
  logic             push, full, pop, empty;
  logic [RES_W-1:0] res_bits;
  logic [CNT_W-1:0] cnt_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpr       <= CPR_RESET;
      cfg_q.max_speed <= MAX_SPEED_RESET;
      cfg_q.max_step  <= MAX_STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CPR:       cfg_q.cpr       <= cfg_wdata_i;
        CFG_MAX_SPEED: cfg_q.max_speed <= cfg_wdata_i;
        CFG_MAX_STEP:  cfg_q.max_step  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  esp_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .timestamp_us_i (timestamp_us_i),
    .chb_level_i    (chb_level_i),
    .unit_mode_i    (unit_mode_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  esp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (fifo_rdata),
    .empty_o (empty)
  );

  esp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_t'(fifo_rdata)),
    .empty_i        (empty),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (res_bits),
    .count_now_o    (cnt_bits)
  );

  assign result_value_o = signed'(res_bits);
  assign count_now_o    = signed'(cnt_bits);

endmodule

FILE: src/esp_checker.sv
// Port-level checks for the encoder speed and position unit, bound to the top level.
module esp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [esp_pkg::RES_W-1:0] result_value_o,
  input logic signed [esp_pkg::CNT_W-1:0] count_now_o
);
  import esp_pkg::*;

  logic [2:0]       pend_q;
  logic [CNT_W-1:0] last_cnt_q;
  logic             have_q;
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_step;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_o & ~out_stall_i;
  assign cnt_step = count_now_o - last_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_cnt_q <= '0;
      have_q     <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 1'b1;
      end else if (out_acc && !in_acc) begin
        pend_q <= pend_q - 1'b1;
      end
      if (out_acc) begin
        last_cnt_q <= count_now_o;
        have_q     <= 1'b1;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(result_value_o) && $stable(count_now_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result shown with no transaction outstanding");

  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> !in_stall_o)
    else $error("empty unit stalls its input");

  // successive results move the count by at most one edge
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q |->
      (cnt_step == '0) || (cnt_step == CNT_W'(1)) || (cnt_step == '1))
    else $error("count jumped between results");

endmodule

bind encoder_speed_position esp_checker u_esp_checker (.*);
